[design/tst_pkg.sv]
package tst_pkg;

  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;
  localparam int Q14_ONE   = 16384;

  // Lane pipeline: five front stages, one square-root step per stage,
  // a divider load stage, one quotient bit per stage, and the result register.
  localparam int FRONT_STAGES = 5;
  localparam int SQ_STEPS     = 32;
  localparam int DIV_STEPS    = 16;
  localparam int LANE_LAT     = FRONT_STAGES + SQ_STEPS + 1 + DIV_STEPS + 1;

  // Point divide: |c| * 2^16 has 48 bits.
  localparam int PDIV_BITS = 48;

  typedef enum logic [2:0] {
    REG_LIGHT_X = 3'd0,
    REG_LIGHT_Y = 3'd1,
    REG_LIGHT_Z = 3'd2,
    REG_LIGHT_W = 3'd3,
    REG_EYE_X   = 3'd4,
    REG_EYE_Y   = 3'd5,
    REG_EYE_Z   = 3'd6,
    REG_EYE_W   = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LOAD,
    SEQ_DIV,
    SEQ_STORE
  } seq_state_e;

  localparam logic [31:0] REG_RESET [NUM_REGS] = '{
    32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0
  };

endpackage

[design/tst_lane.sv]
module tst_lane import tst_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic               point_i,
  input  logic signed [31:0] base_i [3],
  input  logic signed [31:0] pos_i  [3],
  input  logic signed [15:0] nrm_i  [3],
  output logic signed [15:0] res_o
);

  // Stage 1: direction, sign and magnitude.
  logic signed [32:0] dir1    [3];
  logic        [32:0] mag1_d  [3];
  logic        [32:0] mag1_q  [3];
  logic        [2:0]  neg1_d, neg1_q;
  logic signed [15:0] nrm1_q  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir1[i] = point_i ? (33'(base_i[i]) - 33'(pos_i[i])) : 33'(base_i[i]);
      neg1_d[i] = dir1[i][32];
      mag1_d[i] = dir1[i][32] ? 33'(-dir1[i]) : 33'(dir1[i]);
    end
  end

  // Stage 2: largest magnitude and its leading one.
  logic [32:0] mmax2;
  logic [5:0]  msb2_d, msb2_q;
  logic        zero2_d, zero2_q;
  logic [32:0] mag2_q [3];
  logic [2:0]  neg2_q;
  logic signed [15:0] nrm2_q [3];

  always_comb begin
    mmax2 = mag1_q[0];
    if (mag1_q[1] > mmax2) mmax2 = mag1_q[1];
    if (mag1_q[2] > mmax2) mmax2 = mag1_q[2];
    msb2_d = '0;
    for (int k = 0; k < 33; k++) begin
      if (mmax2[k]) msb2_d = 6'(k);
    end
    zero2_d = (mmax2 == '0);
  end

  // Stage 3: block scaling so the largest magnitude lands in [2^30, 2^31).
  logic [32:0] sh3    [3];
  logic [30:0] sc3_d  [3];
  logic [30:0] sc3_q  [3];
  logic [2:0]  neg3_q;
  logic        zero3_q;
  logic signed [15:0] nrm3_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (msb2_q >= 6'd30) begin
        sh3[i] = mag2_q[i] >> (msb2_q - 6'd30);
      end else begin
        sh3[i] = mag2_q[i] << (6'd30 - msb2_q);
      end
      sc3_d[i] = sh3[i][30:0];
    end
  end

  // Stage 4: squares and normal products.
  logic signed [31:0] sd4   [3];
  logic        [61:0] sq4_d [3];
  logic        [61:0] sq4_q [3];
  logic signed [47:0] pr4_d [3];
  logic signed [47:0] pr4_q [3];
  logic               zero4_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sd4[i]   = neg3_q[i] ? -$signed({1'b0, sc3_q[i]}) : $signed({1'b0, sc3_q[i]});
      sq4_d[i] = 62'(sc3_q[i]) * 62'(sc3_q[i]);
      pr4_d[i] = 48'(nrm3_q[i]) * 48'(sd4[i]);
    end
  end

  // Stage 5: sums; the dot product is split into magnitude and sign.
  logic        [63:0] s2_5;
  logic signed [49:0] dot5;
  logic        [47:0] an5;

  always_comb begin
    s2_5 = 64'(sq4_q[0]) + 64'(sq4_q[1]) + 64'(sq4_q[2]);
    dot5 = 50'(pr4_q[0]) + 50'(pr4_q[1]) + 50'(pr4_q[2]);
    an5  = dot5[49] ? 48'(-dot5) : 48'(dot5);
  end

  // Square root, one result bit per stage.
  logic [63:0] sv_q  [SQ_STEPS+1];
  logic [63:0] sr_q  [SQ_STEPS+1];
  logic [47:0] san_q [SQ_STEPS+1];
  logic        ssg_q [SQ_STEPS+1];
  logic        szr_q [SQ_STEPS+1];
  logic [63:0] sv_d  [SQ_STEPS];
  logic [63:0] sr_d  [SQ_STEPS];
  logic [63:0] sbit  [SQ_STEPS];
  logic [63:0] stry  [SQ_STEPS];

  always_comb begin
    for (int j = 0; j < SQ_STEPS; j++) begin
      sbit[j] = 64'd1 << (62 - 2 * j);
      stry[j] = sr_q[j] + sbit[j];
      if (sv_q[j] >= stry[j]) begin
        sv_d[j] = sv_q[j] - stry[j];
        sr_d[j] = (sr_q[j] >> 1) + sbit[j];
      end else begin
        sv_d[j] = sv_q[j];
        sr_d[j] = sr_q[j] >> 1;
      end
    end
  end

  // Divider load: quotient of (2|N| + L) by 2L, which rounds |N| / L.
  logic [31:0] len_l;
  logic [49:0] rem_l;
  logic [32:0] dd_l;
  logic        sat_l;

  always_comb begin
    len_l = sr_q[SQ_STEPS][31:0];
    rem_l = (50'(san_q[SQ_STEPS]) << 1) + 50'(len_l);
    dd_l  = {len_l, 1'b0};
    sat_l = rem_l >= (50'(dd_l) << (DIV_STEPS - 1));
  end

  logic [49:0] dr_q  [DIV_STEPS+1];
  logic [15:0] dq_q  [DIV_STEPS+1];
  logic [32:0] dd_q  [DIV_STEPS+1];
  logic        dsat_q[DIV_STEPS+1];
  logic        dsg_q [DIV_STEPS+1];
  logic        dzr_q [DIV_STEPS+1];
  logic [49:0] dr_d  [DIV_STEPS];
  logic [15:0] dq_d  [DIV_STEPS];
  logic [49:0] dtry  [DIV_STEPS];

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      dtry[k] = 50'(dd_q[k]) << (DIV_STEPS - 1 - k);
      if (dr_q[k] >= dtry[k]) begin
        dr_d[k] = dr_q[k] - dtry[k];
        dq_d[k] = {dq_q[k][14:0], 1'b1};
      end else begin
        dr_d[k] = dr_q[k];
        dq_d[k] = {dq_q[k][14:0], 1'b0};
      end
    end
  end

  // Result: saturate to one, apply the sign, and give zero for a zero-length direction.
  logic [14:0] mq_f;
  logic signed [15:0] res_d, res_q;

  always_comb begin
    if (dsat_q[DIV_STEPS] || (dq_q[DIV_STEPS] > 16'(Q14_ONE))) begin
      mq_f = 15'(Q14_ONE);
    end else begin
      mq_f = dq_q[DIV_STEPS][14:0];
    end
    if (dzr_q[DIV_STEPS]) begin
      res_d = '0;
    end else if (dsg_q[DIV_STEPS]) begin
      res_d = -$signed({1'b0, mq_f});
    end else begin
      res_d = $signed({1'b0, mq_f});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q  <= mag1_d;
      neg1_q  <= neg1_d;
      nrm1_q  <= nrm_i;

      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      nrm2_q  <= nrm1_q;
      msb2_q  <= msb2_d;
      zero2_q <= zero2_d;

      sc3_q   <= sc3_d;
      neg3_q  <= neg2_q;
      nrm3_q  <= nrm2_q;
      zero3_q <= zero2_q;

      sq4_q   <= sq4_d;
      pr4_q   <= pr4_d;
      zero4_q <= zero3_q;

      sv_q[0]  <= s2_5;
      sr_q[0]  <= '0;
      san_q[0] <= an5;
      ssg_q[0] <= dot5[49];
      szr_q[0] <= zero4_q;
      for (int j = 0; j < SQ_STEPS; j++) begin
        sv_q[j+1]  <= sv_d[j];
        sr_q[j+1]  <= sr_d[j];
        san_q[j+1] <= san_q[j];
        ssg_q[j+1] <= ssg_q[j];
        szr_q[j+1] <= szr_q[j];
      end

      dr_q[0]   <= rem_l;
      dq_q[0]   <= '0;
      dd_q[0]   <= dd_l;
      dsat_q[0] <= sat_l;
      dsg_q[0]  <= ssg_q[SQ_STEPS];
      dzr_q[0]  <= szr_q[SQ_STEPS];
      for (int k = 0; k < DIV_STEPS; k++) begin
        dr_q[k+1]   <= dr_d[k];
        dq_q[k+1]   <= dq_d[k];
        dd_q[k+1]   <= dd_q[k];
        dsat_q[k+1] <= dsat_q[k];
        dsg_q[k+1]  <= dsg_q[k];
        dzr_q[k+1]  <= dzr_q[k];
      end

      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

[design/toon_shade_texcoord.sv]
// Toon-shading texture coordinates, one vertex per beat. Each input beat carries a
// Q16.16 position and a Q1.14 normal; each output beat carries tex_s (normal dot the
// normalized light direction) and tex_t (normal dot the normalized eye direction),
// both rounded half away from zero and saturated to +/-1.0 in Q1.14, plus the
// last_vertex flag. Light and eye are homogeneous Q16.16 positions in registers 0-3
// and 4-7; a nonzero w makes a point (divided by w, then the vertex is subtracted),
// a zero w makes a fixed direction, and a zero-length direction gives 0. The block
// takes a new vertex every cycle while in_stall_o is low; the pipeline depth is set
// by the square root and the rounding divide, each resolved one bit per pipeline
// stage. When the output is stalled the whole pipeline holds. After every register
// write the block computes the six point quotients with a shared one-bit-per-cycle
// divider and holds in_stall_o high until all six are stored (six 48-bit divides,
// each with a load and a store state); the write port itself is always ready.
module toon_shade_texcoord import tst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [31:0]   pos_x_i,
  input  logic signed [31:0]   pos_y_i,
  input  logic signed [31:0]   pos_z_i,
  input  logic signed [15:0]   nrm_x_i,
  input  logic signed [15:0]   nrm_y_i,
  input  logic signed [15:0]   nrm_z_i,
  input  logic                 last_vertex_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [15:0]   tex_s_o,
  output logic signed [15:0]   tex_t_o,
  output logic                 last_out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  // Configuration registers. Indexes beyond the list are ignored.
  logic [31:0] regs_q [NUM_REGS];
  logic        cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we = cfg_valid_i && cfg_ready_o && (cfg_index_i < CFG_IDX_W'(NUM_REGS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= REG_RESET;
    end else if (cfg_we) begin
      regs_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  // Point quotients c * 2^16 / w, truncated toward zero and saturated to 32 bits.
  // Entries 0-2 belong to the light, 3-5 to the eye. The sequencer restarts on
  // every register write, so the quotients match the current registers whenever it is idle.
  seq_state_e        state_q, state_d;
  logic [2:0]        dix_q, dix_d;
  logic [5:0]        cnt_q, cnt_d;
  logic [PDIV_BITS-1:0] num_q, num_d;
  logic [PDIV_BITS-1:0] quo_q, quo_d;
  logic [31:0]       rem_q, rem_d;
  logic [31:0]       dv_q, dv_d;
  logic              dneg_q, dneg_d;
  logic [31:0]       p_q [6];
  logic              p_we;
  logic [31:0]       p_val;

  logic [2:0]        src_idx;
  logic signed [31:0] src_c, src_w;
  logic [31:0]       abs_c, abs_w;
  logic [32:0]       sh_rem;

  always_comb begin
    src_idx = (dix_q < 3'd3) ? dix_q : (dix_q + 3'd1);
    src_c   = $signed(regs_q[src_idx]);
    src_w   = (dix_q < 3'd3) ? $signed(regs_q[REG_LIGHT_W]) : $signed(regs_q[REG_EYE_W]);
    abs_c   = src_c[31] ? 32'(-src_c) : 32'(src_c);
    abs_w   = src_w[31] ? 32'(-src_w) : 32'(src_w);
    sh_rem  = {rem_q, num_q[PDIV_BITS-1]};
  end

  always_comb begin
    state_d = state_q;
    dix_d   = dix_q;
    cnt_d   = cnt_q;
    num_d   = num_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    dv_d    = dv_q;
    dneg_d  = dneg_q;
    p_we    = 1'b0;
    p_val   = quo_q[31:0];

    case (state_q)
      SEQ_IDLE: begin
      end
      SEQ_LOAD: begin
        num_d   = {abs_c, 16'd0};
        quo_d   = '0;
        rem_d   = '0;
        dv_d    = abs_w;
        dneg_d  = src_c[31] ^ src_w[31];
        cnt_d   = 6'(PDIV_BITS - 1);
        state_d = SEQ_DIV;
      end
      SEQ_DIV: begin
        num_d = num_q << 1;
        if (sh_rem >= {1'b0, dv_q}) begin
          rem_d = 32'(sh_rem - {1'b0, dv_q});
          quo_d = {quo_q[PDIV_BITS-2:0], 1'b1};
        end else begin
          rem_d = sh_rem[31:0];
          quo_d = {quo_q[PDIV_BITS-2:0], 1'b0};
        end
        if (cnt_q == '0) begin
          state_d = SEQ_STORE;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      SEQ_STORE: begin
        p_we = 1'b1;
        if (dneg_q) begin
          if (quo_q > PDIV_BITS'(32'h8000_0000)) begin
            p_val = 32'h8000_0000;
          end else begin
            p_val = 32'(-quo_q);
          end
        end else if (quo_q > PDIV_BITS'(32'h7FFF_FFFF)) begin
          p_val = 32'h7FFF_FFFF;
        end else begin
          p_val = quo_q[31:0];
        end
        if (dix_q == 3'd5) begin
          state_d = SEQ_IDLE;
        end else begin
          dix_d   = dix_q + 3'd1;
          state_d = SEQ_LOAD;
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase

    if (cfg_we) begin
      state_d = SEQ_LOAD;
      dix_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      dix_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      dix_q   <= dix_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dv_q   <= dv_d;
    dneg_q <= dneg_d;
    if (p_we) begin
      p_q[dix_q] <= p_val;
    end
  end

  // Pipeline control: every stage advances unless a finished beat is stalled.
  logic                en;
  logic                in_acc;
  logic [LANE_LAT-1:0] vld_q;
  logic [LANE_LAT-1:0] lst_q;

  assign en         = !(vld_q[LANE_LAT-1] && out_stall_i);
  assign in_stall_o = !en || (state_q != SEQ_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LANE_LAT-2:0], in_acc};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lst_q <= {lst_q[LANE_LAT-2:0], last_vertex_i};
    end
  end

  // Direction sources for the two lanes.
  logic               light_pt, eye_pt;
  logic signed [31:0] light_b [3];
  logic signed [31:0] eye_b   [3];
  logic signed [31:0] pos_a   [3];
  logic signed [15:0] nrm_a   [3];

  always_comb begin
    light_pt = (regs_q[REG_LIGHT_W] != '0);
    eye_pt   = (regs_q[REG_EYE_W] != '0);
    light_b[0] = $signed(light_pt ? p_q[0] : regs_q[REG_LIGHT_X]);
    light_b[1] = $signed(light_pt ? p_q[1] : regs_q[REG_LIGHT_Y]);
    light_b[2] = $signed(light_pt ? p_q[2] : regs_q[REG_LIGHT_Z]);
    eye_b[0]   = $signed(eye_pt ? p_q[3] : regs_q[REG_EYE_X]);
    eye_b[1]   = $signed(eye_pt ? p_q[4] : regs_q[REG_EYE_Y]);
    eye_b[2]   = $signed(eye_pt ? p_q[5] : regs_q[REG_EYE_Z]);
    pos_a[0] = pos_x_i;
    pos_a[1] = pos_y_i;
    pos_a[2] = pos_z_i;
    nrm_a[0] = nrm_x_i;
    nrm_a[1] = nrm_y_i;
    nrm_a[2] = nrm_z_i;
  end

  tst_lane u_light (
    .clk_i   (clk_i),
    .en_i    (en),
    .point_i (light_pt),
    .base_i  (light_b),
    .pos_i   (pos_a),
    .nrm_i   (nrm_a),
    .res_o   (tex_s_o)
  );

  tst_lane u_eye (
    .clk_i   (clk_i),
    .en_i    (en),
    .point_i (eye_pt),
    .base_i  (eye_b),
    .pos_i   (pos_a),
    .nrm_i   (nrm_a),
    .res_o   (tex_t_o)
  );

  assign out_valid_o = vld_q[LANE_LAT-1];
  assign last_out_o  = lst_q[LANE_LAT-1];

endmodule

[sim/toon_shade_texcoord_test.sv]
// Testbench for toon_shade_texcoord.
//
// A vertex stream is driven into the block while its light and eye registers
// are changed between phases. A predictor in this file or a typed-in table row
// gives tex_s, tex_t and the last flag for every vertex beat that the block
// accepts, and the receiving side compares each output beat with the oldest
// prediction. Both sides idle at random, and some phases run with no idling at all.
module toon_shade_texcoord_test;
  import tst_pkg::*;

  localparam int RAND_PHASES = 11;
  localparam int PHASE_ITEMS = 118;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_CYCLES = LANE_LAT + 10;

  typedef struct {
    logic signed [15:0] s;
    logic signed [15:0] t;
    logic               last;
  } texcoord_t;

  // One row of the directed vertex table. Where known is set, the
  // expected coordinates are typed in; otherwise the predictor supplies them.
  typedef struct {
    int      px, py, pz;
    shortint nx, ny, nz;
    bit      last;
    bit      known;
    shortint s, t;
  } vertex_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic signed [31:0]   pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [15:0]   nrm_x_i = '0, nrm_y_i = '0, nrm_z_i = '0;
  logic                 last_vertex_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [15:0]   tex_s_o, tex_t_o;
  logic                 last_out_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [31:0]          cfg_data_i = '0;

  toon_shade_texcoord dut (.*);

  always #5 clk_i = ~clk_i;

  // Predictor copy of the light and eye registers.
  logic [31:0] shade_regs [NUM_REGS];
  texcoord_t   coord_q [$];
  int          mismatches = 0;
  int          beats_in = 0;
  int          beats_out = 0;
  int          reg_writes = 0;
  bit          idle_on = 1'b1;

  // Homogeneous point coordinate divided by w, truncated toward zero and
  // clamped to the 32 bit range.
  function automatic longint point_coord(logic signed [31:0] c, logic signed [31:0] w);
    longint p;
    p = (longint'(c) * 65536) / longint'(w);
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Normal dotted with the normalized direction toward one light source,
  // base selects the light (0) or the eye (4) registers.
  function automatic logic signed [15:0] shade_dot(int base, longint pos [3], longint nrm [3]);
    longint          d [3];
    longint unsigned mag [3];
    bit              neg [3];
    longint unsigned m, s2, len, q, an;
    longint          dot, sd;
    logic signed [31:0] w;
    w = shade_regs[base + 3];
    dot = 0;
    s2 = 0;
    for (int i = 0; i < 3; i++) begin
      if (w != 0) d[i] = point_coord(shade_regs[base + i], w) - pos[i];
      else d[i] = longint'($signed(shade_regs[base + i]));
      neg[i] = d[i] < 0;
      mag[i] = neg[i] ? -d[i] : d[i];
    end
    m = mag[0];
    if (mag[1] > m) m = mag[1];
    if (mag[2] > m) m = mag[2];
    if (m == 0) return '0;
    while (m >= (64'd1 << 31)) begin
      m >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (m < (64'd1 << 30)) begin
      m <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) begin
      sd = neg[i] ? -longint'(mag[i]) : longint'(mag[i]);
      s2 += mag[i] * mag[i];
      dot += nrm[i] * sd;
    end
    len = int_sqrt(s2);
    if (len == 0) return '0;
    an = dot < 0 ? -dot : dot;
    // Round half away from zero, then clamp to one in Q1.14.
    q = (2 * an + len) / (2 * len);
    if (q > Q14_ONE) q = Q14_ONE;
    return dot < 0 ? -16'(q) : 16'(q);
  endfunction

  function automatic texcoord_t predict_texcoord();
    longint    pos [3];
    longint    nrm [3];
    texcoord_t c;
    pos = '{pos_x_i, pos_y_i, pos_z_i};
    nrm = '{nrm_x_i, nrm_y_i, nrm_z_i};
    c.s = shade_dot(REG_LIGHT_X, pos, nrm);
    c.t = shade_dot(REG_EYE_X, pos, nrm);
    c.last = last_vertex_i;
    return c;
  endfunction

  // Output side: checks every accepted beat and draws its own stalls.
  int stall_left = 0;
  always @(posedge clk_i) begin
    texcoord_t want;
    bit        took;
    took = out_valid_o && !out_stall_i;
    if (took) begin
      beats_out++;
      if (coord_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected output beat: s=%0d t=%0d last=%0b",
                   tex_s_o, tex_t_o, last_out_o);
      end else begin
        want = coord_q.pop_front();
        if (tex_s_o !== want.s || tex_t_o !== want.t || last_out_o !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"mismatch at beat %0d: expected s=%0d t=%0d last=%0b, ",
                      "got s=%0d t=%0d last=%0b"},
                     beats_out, want.s, want.t, want.last, tex_s_o, tex_t_o, last_out_o);
        end
      end
    end
    if (took && idle_on) begin
      stall_left = $urandom_range(0, 7);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Writes one register; indexes past the last register are ignored by both
  // the block and the predictor. The channel goes idle after each write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx < NUM_REGS) shade_regs[idx[2:0]] = value;
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic write_source(int base, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z, logic [31:0] w);
    write_reg(CFG_IDX_W'(base), x);
    write_reg(CFG_IDX_W'(base + 1), y);
    write_reg(CFG_IDX_W'(base + 2), z);
    write_reg(CFG_IDX_W'(base + 3), w);
  endtask

  // Draws one light or eye source: a direction, a point at unit w,
  // a point at an arbitrary w, or a zero direction.
  task automatic random_source(int base);
    logic [31:0] v [3];
    logic [31:0] w;
    for (int i = 0; i < 3; i++)
      v[i] = ($urandom_range(0, 1) != 0) ? $urandom() : 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
    case ($urandom_range(0, 5))
      0, 1: w = '0;
      2, 3: w = 32'd65536;
      4: w = $urandom();
      default: begin
        w = '0;
        v = '{default: '0};
      end
    endcase
    write_source(base, v[0], v[1], v[2], w);
  endtask

  // Puts one vertex on the input port and waits for the block to take it.
  task automatic send_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                             logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                             logic last, bit known, texcoord_t fixed);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= px;
    pos_y_i <= py;
    pos_z_i <= pz;
    nrm_x_i <= nx;
    nrm_y_i <= ny;
    nrm_z_i <= nz;
    last_vertex_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    coord_q.push_back(known ? fixed : predict_texcoord());
    beats_in++;
  endtask

  task automatic random_vertex();
    logic [31:0] p [3];
    logic [15:0] n [3];
    int          mode;
    texcoord_t   none;
    none = '{default: '0};
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      case (mode)
        0, 1, 2: p[i] = $urandom();
        3: begin
          case ($urandom_range(0, 3))
            0: p[i] = 32'h8000_0000;
            1: p[i] = 32'h7fff_ffff;
            2: p[i] = 32'hffff_ffff;
            default: p[i] = '0;
          endcase
        end
        // When the light is a point, the vertex is placed on it, so the light direction has no length.
        4: p[i] = (shade_regs[REG_LIGHT_W] != 0) ?
                  32'(point_coord(shade_regs[REG_LIGHT_X + i], shade_regs[REG_LIGHT_W]))
                  : $urandom();
        default: p[i] = 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      endcase
      // Mostly normal-range components, sometimes any bit pattern.
      n[i] = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                         : 16'($signed($urandom_range(0, 32768)) - 16384);
    end
    send_vertex(p[0], p[1], p[2], n[0], n[1], n[2], 1'($urandom_range(0, 1)), 1'b0, none);
  endtask

  // Stops sending until every prediction has been checked, then lets the
  // pipeline settle before registers are touched.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (coord_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Directed vertices under the reset registers: light and eye both point
  // straight along +z, so each coordinate is just the normal's z clamped to one.
  vertex_row_t reset_rows [] = '{
    '{0, 0, 0, 0, 0, 16384, 1'b0, 1'b1, 16384, 16384},
    '{0, 0, 0, 0, 0, -16384, 1'b1, 1'b1, -16384, -16384},
    '{32'h7fffffff, 32'h80000000, -1, 16384, 0, 0, 1'b0, 1'b1, 0, 0},
    '{0, 0, 0, 0, 0, 32767, 1'b0, 1'b1, 16384, 16384},
    '{0, 0, 0, 0, 0, -32768, 1'b1, 1'b1, -16384, -16384},
    '{0, 0, 0, -32768, -32768, -32768, 1'b0, 1'b1, -16384, -16384},
    '{0, 0, 0, 0, 0, 8192, 1'b0, 1'b1, 8192, 8192},
    '{0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 0, 0},
    '{5, -7, 9, 11585, 0, 11585, 1'b0, 1'b0, 0, 0},
    '{0, 0, 0, 9459, -9459, 9459, 1'b1, 1'b0, 0, 0}
  };

  // Directed vertices for the point and extreme settings, checked by the predictor.
  vertex_row_t point_rows [] = '{
    '{0, 0, 0, 16384, 0, 0, 1'b0, 1'b0, 0, 0},
    '{65536, 0, 0, 0, 16384, 0, 1'b1, 1'b0, 0, 0},
    '{32'h80000000, 32'h80000000, 32'h80000000, 16384, 16384, 16384, 1'b0, 1'b0, 0, 0},
    '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, -16384, -16384, -16384, 1'b1, 1'b0, 0, 0},
    '{-65536, 131072, -196608, 11585, -11585, 0, 1'b0, 1'b0, 0, 0},
    '{0, 0, 65536, 0, 0, 16384, 1'b1, 1'b0, 0, 0}
  };

  task automatic run_rows(vertex_row_t rows []);
    texcoord_t fixed;
    foreach (rows[i]) begin
      fixed = '{rows[i].s, rows[i].t, rows[i].last};
      send_vertex(rows[i].px, rows[i].py, rows[i].pz, rows[i].nx, rows[i].ny,
                  rows[i].nz, rows[i].last, rows[i].known, fixed);
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) shade_regs[i] = REG_RESET[i];
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_rows(reset_rows);
    drain();

    // Light as a point one unit up z, eye as a zero direction.
    write_source(REG_LIGHT_X, 32'd0, 32'd0, 32'd65536, 32'd65536);
    write_source(REG_EYE_X, 32'd0, 32'd0, 32'd0, 32'd0);
    run_rows(point_rows);
    drain();

    // Extreme coordinates over a tiny w, so the point divide clamps, and an
    // eye at the most negative w.
    write_source(REG_LIGHT_X, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'd1);
    write_source(REG_EYE_X, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'h8000_0000);
    run_rows(point_rows);
    drain();

    // Writes past the last register must leave the setting alone.
    for (int i = NUM_REGS; i < (1 << CFG_IDX_W); i++) write_reg(CFG_IDX_W'(i), $urandom());
    write_source(REG_EYE_X, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff);
    run_rows(point_rows);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_on = (ph % 4) != 1;
      random_source(REG_LIGHT_X);
      random_source(REG_EYE_X);
      for (int k = 0; k < PHASE_ITEMS; k++) random_vertex();
      drain();
    end
    idle_on = 1'b1;

    $display("Covered %0d vertex beats in and %0d out, %0d register writes,",
             beats_in, beats_out, reg_writes);
    $display("directional, point, zero-length and clamped light and eye settings.");
    if (mismatches == 0 && coord_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[toon_shade_texcoord.f]
design/tst_pkg.sv
design/tst_lane.sv
design/toon_shade_texcoord.sv
sim/toon_shade_texcoord_test.sv
